>>> sv/assert_macros.svh
// Assertion macros shared by the list RTL.
// No dependencies; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define SAL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("list assertion failed");
// Condition must never be true outside reset.
`define SAL_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("list forbidden condition seen");
`else
`define SAL_ASSERT(lbl, clk, rst_n, prop)
`define SAL_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> sv/sal_pkg.sv
// Shared types and constants for the shifting array list.
// No dependencies; used by the interfaces and every module.
package sal_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STAT_W  = 2;

  // Command codes carried in each request.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_REMOVE_AT  = 3'd4,
    CMD_READ_AT    = 3'd5
  } cmd_e;

  // Status codes returned with each response.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic req_load;  // capture the accepted request
    logic exec;      // apply the held request and load the response register
  } ctl_cmd_t;

endpackage

>>> sv/sal_if.sv
// Valid/ready channel interfaces for list requests and responses.
// Depends on sal_pkg for the field widths.
interface sal_req_if;
  logic                        valid;
  logic                        ready;
  logic [sal_pkg::CMD_W-1:0]   cmd;
  logic [sal_pkg::VALUE_W-1:0] value;
  logic [sal_pkg::POS_W-1:0]   position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink   (input valid, cmd, value, position, output ready);
endinterface

interface sal_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sal_pkg::VALUE_W-1:0] read_value;
  logic [sal_pkg::COUNT_W-1:0] count;
  logic [sal_pkg::STAT_W-1:0]  status;

  modport source (output valid, read_value, count, status, input ready);
  modport sink   (input valid, read_value, count, status, output ready);
endinterface

>>> sv/sal_ctl.sv
// Controller of the list: request and response handshakes and sequencing.
// Depends on sal_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sal_ctl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output sal_pkg::ctl_cmd_t ctl_o
);
  import sal_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } ctl_state_e;

  ctl_state_e state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       slot_free;
  logic       req_fire;

  assign req_ready_o = (state_q == S_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;
  // The response register can take a new result when empty or being drained.
  assign slot_free   = !rsp_valid_q || rsp_ready_i;

  // Next state and command decode.
  always_comb begin
    state_d        = state_q;
    rsp_valid_d    = rsp_valid_q && !rsp_ready_i;
    ctl_o.req_load = 1'b0;
    ctl_o.exec     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          ctl_o.req_load = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          ctl_o.exec  = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  `SAL_ASSERT(a_exec_in_exec, clk_i, rst_ni, ctl_o.exec |-> state_q == S_EXEC)
  `SAL_ASSERT(a_accept_to_exec, clk_i, rst_ni, req_fire |=> state_q == S_EXEC)
  `SAL_ASSERT(a_exec_gives_rsp, clk_i, rst_ni, ctl_o.exec |=> rsp_valid_q)
  `SAL_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
                    ctl_o.exec && rsp_valid_q && !rsp_ready_i)
endmodule

>>> sv/sal_dp.sv
// Datapath of the list: request holding registers, the row of shifting cells,
// the entry count and the response register. Depends on sal_pkg.
module sal_dp #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sal_pkg::ctl_cmd_t             ctl_i,
  input  logic [sal_pkg::CMD_W-1:0]     cmd_i,
  input  logic [sal_pkg::VALUE_W-1:0]   value_i,
  input  logic [sal_pkg::POS_W-1:0]     position_i,
  output logic [sal_pkg::VALUE_W-1:0]   read_value_o,
  output logic [sal_pkg::COUNT_W-1:0]   count_o,
  output logic [sal_pkg::STAT_W-1:0]    status_o
);
  import sal_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned RD_N  = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

  // Held request.
  cmd_e               cmd_q;
  logic [WIDTH-1:0]   word_q;
  logic [POS_W-1:0]   pos_q;

  // List state.
  logic [WIDTH-1:0]   cell_q [DEPTH];
  logic [CNT_W-1:0]   count_q, count_d;

  // Response register.
  logic [VALUE_W-1:0] rd_val_q, rd_val_d;
  logic [COUNT_W-1:0] rsp_cnt_q;
  status_e            stat_q, stat_d;

  // Cell update controls.
  logic               wr_back;
  logic               wr_front;
  logic               shift_dn;
  logic [CMP_W-1:0]   shift_base;

  logic               full;
  logic               empty;
  logic               pos_ok;
  logic [WIDTH-1:0]   rd_word;

  // Capture the accepted request.
  always_ff @(posedge clk_i) begin
    if (ctl_i.req_load) begin
      cmd_q  <= cmd_e'(cmd_i);
      word_q <= WIDTH'(value_i);
      pos_q  <= position_i;
    end
  end

  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  assign pos_ok = (CMP_W'(pos_q) < CMP_W'(count_q));

  // Read multiplexer over the positions a request can name.
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (pos_q == POS_W'(k)) begin
        rd_word = cell_q[k];
      end
    end
  end

  // Command decode: status, new count and cell controls.
  always_comb begin
    count_d    = count_q;
    stat_d     = STAT_OK;
    rd_val_d   = '0;
    wr_back    = 1'b0;
    wr_front   = 1'b0;
    shift_dn   = 1'b0;
    shift_base = '0;
    case (cmd_q)
      CMD_PUSH_BACK: begin
        if (full) begin
          stat_d = STAT_FULL;
        end else begin
          wr_back = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          stat_d = STAT_FULL;
        end else begin
          wr_front = 1'b1;
          count_d  = count_q + 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          stat_d = STAT_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          stat_d = STAT_EMPTY;
        end else begin
          shift_dn = 1'b1;
          count_d  = count_q - 1'b1;
        end
      end
      CMD_REMOVE_AT: begin
        if (!pos_ok) begin
          stat_d = STAT_RANGE;
        end else begin
          shift_dn   = 1'b1;
          shift_base = CMP_W'(pos_q);
          count_d    = count_q - 1'b1;
        end
      end
      CMD_READ_AT: begin
        if (!pos_ok) begin
          stat_d = STAT_RANGE;
        end else begin
          rd_val_d = VALUE_W'(rd_word);
        end
      end
      default: begin
        // Unused command codes leave the list as it is.
      end
    endcase
  end

  // Row of cells; each one takes the request word or a neighbor's word.
  // Words written above the count are never read before being rewritten.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] below;
    logic [WIDTH-1:0] above;
    logic             take_above;

    if (i == 0) begin : g_first
      assign below = word_q;
    end else begin : g_inner
      assign below = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign above      = cell_q[i];
      assign take_above = 1'b0;
    end else begin : g_mid
      assign above      = cell_q[i+1];
      assign take_above = shift_dn && (CMP_W'(i) >= shift_base);
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.exec) begin
        if (wr_front) begin
          cell_q[i] <= below;
        end else if (take_above) begin
          cell_q[i] <= above;
        end else if (wr_back && (count_q == CNT_W'(i))) begin
          cell_q[i] <= word_q;
        end
      end
    end
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.exec) begin
      count_q <= count_d;
    end
  end

  // Response register.
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      rd_val_q  <= rd_val_d;
      rsp_cnt_q <= COUNT_W'(count_d);
      stat_q    <= stat_d;
    end
  end

  assign read_value_o = rd_val_q;
  assign count_o      = rsp_cnt_q;
  assign status_o     = stat_q;
endmodule

>>> sv/shifting_array_list.sv
// Top level of the shifting array list: controller plus datapath.
// Depends on sal_pkg, sal_if, sal_ctl and sal_dp.
//
//   Channel  Dir  Fields                        Handshake
//   req_i    in   cmd, value, position          valid/ready
//   rsp_o    out  read_value, count, status     valid/ready
//
// Each request is first captured in S_IDLE, then applied in S_EXEC to the
// row of cells, where every cell moves toward its neighbor in parallel.
// One request is in flight at a time; the next is taken while a response waits.
// A stalled response holds the apply step until its register drains.
// Reset clears the entry count and the handshake state; cell contents are
// undefined until written and need no clearing pass.
module shifting_array_list #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  sal_req_if.sink   req_i,
  sal_rsp_if.source rsp_o
);
  import sal_pkg::*;

  ctl_cmd_t ctl;

  sal_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .ctl_o       (ctl)
  );

  sal_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .cmd_i        (req_i.cmd),
    .value_i      (req_i.value),
    .position_i   (req_i.position),
    .read_value_o (rsp_o.read_value),
    .count_o      (rsp_o.count),
    .status_o     (rsp_o.status)
  );
endmodule
